// File: design/ebu_pkg.sv
package ebu_pkg;

  localparam int GRAY_W = 8;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 11;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [4:0]  RST_WINDOW_SIZE  = 5'd3;
  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd256;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd256;

  typedef struct packed {
    logic [GRAY_W-1:0] eroded_gray;
    logic [GRAY_W-1:0] boundary_gray;
    logic              frame_end;
  } res_t;

endpackage

// File: design/ebu_ram.sv
module ebu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ebu_window.sv
module ebu_window import ebu_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 17
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [$clog2(MAX_WIDTH)-1:0]       col,
  input  logic                               pix_bit,
  input  logic [GRAY_W-1:0]                  gray_in,
  input  logic                               emit,
  input  logic [$clog2(MAX_HEIGHT)-1:0]      er,
  input  logic [$clog2(MAX_WIDTH)-1:0]       ec,
  input  logic                               fe,
  input  logic                               lag0,
  input  logic [GRAY_W-1:0]                  gray_rd,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    s_eff,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    ahead,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     w_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    h_eff,
  output logic                               res_vld,
  output res_t                               res,
  output logic [1:0]                         inflight
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int HIST = MAX_WINDOW - 1;

  // Stage 1: line store data returns, column vector is formed.
  logic              s1_vld, s1_bit, s1_emit, s1_fe, s1_lag0;
  logic [CW-1:0]     s1_col, s1_ec;
  logic [RW-1:0]     s1_er;
  logic [GRAY_W-1:0] s1_gray;

  logic [HIST-1:0]   line_rd, hist;
  logic [MAX_WINDOW-1:0] col_vec;
  logic              fwd_vld;
  logic [CW-1:0]     fwd_col;
  logic [HIST-1:0]   fwd_data;

  logic [MAX_WINDOW-1:0] win [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] rowok, colok;

  // Stage 2: window is complete, erosion is evaluated.
  logic                  s2_vld, s2_fe;
  logic [GRAY_W-1:0]     s2_center;
  logic [MAX_WINDOW-1:0] s2_rowok, s2_colok;
  logic                  fit;
  logic [GRAY_W-1:0]     eroded;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      fwd_vld <= 1'b0;
    end else begin
      s1_vld <= step;
      s2_vld <= s1_vld && s1_emit;
      fwd_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_bit  <= pix_bit;
    s1_col  <= col;
    s1_emit <= emit;
    s1_er   <= er;
    s1_ec   <= ec;
    s1_fe   <= fe;
    s1_lag0 <= lag0;
    s1_gray <= gray_in;
    fwd_col <= s1_col;
    fwd_data <= col_vec[HIST-1:0];
    s2_fe     <= s1_fe;
    s2_center <= s1_lag0 ? s1_gray : gray_rd;
    s2_rowok  <= rowok;
    s2_colok  <= colok;
  end

  ebu_ram #(.WIDTH(HIST), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (s1_vld),
    .waddr (s1_col),
    .wdata (col_vec[HIST-1:0]),
    .raddr (col),
    .rdata (line_rd)
  );

  // With a one-pixel row the same column is read while it is being written.
  assign hist    = (fwd_vld && fwd_col == s1_col) ? fwd_data : line_rd;
  assign col_vec = {hist, s1_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        win[j] <= '0;
      end
    end else if (s1_vld) begin
      win[0] <= col_vec;
      for (int j = 1; j < MAX_WINDOW; j++) begin
        win[j] <= win[j-1];
      end
    end
  end

  // Column j of the window is the input pixel j places back, which sits at
  // output column ec + ahead - j; bit k of a column is row er + ahead - k.
  always_comb begin
    int ra;
    int ca;
    ra = int'(s1_er) + int'(ahead);
    ca = int'(s1_ec) + int'(ahead);
    for (int k = 0; k < MAX_WINDOW; k++) begin
      rowok[k] = (k < int'(s_eff)) && (ra >= k) && (ra < int'(h_eff) + k);
      colok[k] = (k < int'(s_eff)) && (ca >= k) && (ca < int'(w_eff) + k);
    end
  end

  always_comb begin
    fit = 1'b1;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        if (s2_colok[j] && s2_rowok[k] && !win[j][k]) begin
          fit = 1'b0;
        end
      end
    end
  end

  assign eroded            = fit ? s2_center : '0;
  assign res_vld           = s2_vld;
  assign res.eroded_gray   = eroded;
  assign res.boundary_gray = (eroded == '0) ? s2_center : '0;
  assign res.frame_end     = s2_fe;
  assign inflight          = {1'b0, s1_vld} + {1'b0, s2_vld};

endmodule

// File: design/ebu_fifo.sv
module ebu_fifo import ebu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  res_t       push_data,
  output logic       pop_vld,
  input  logic       pop_rdy,
  output res_t       pop_data,
  output logic [2:0] count
);

  res_t       mem [4];
  logic [1:0] wp, rp;
  logic       pop;

  assign pop      = pop_vld && pop_rdy;
  assign pop_vld  = (count != 3'd0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

// File: design/binary_erosion_boundary_unit.sv
// Throughput: one pixel item per cycle, sustained, while results are taken.
// Order: the result for raster pixel q leaves the output queue after the item
// at q + lag is accepted and has passed the window pipeline, lag = A*W + A with A = S-1-S/2.
// The pace is set by the line store read-modify-write, one column per cycle.
// Reset: registers return to 3 / 256 / 256, counters and queue clear; the line
// and delay memories are not cleared and need no clearing pass.
module binary_erosion_boundary_unit import ebu_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [GRAY_W-1:0] pixel_gray,
  input  logic              drain,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [GRAY_W-1:0] eroded_gray,
  output logic [GRAY_W-1:0] boundary_gray,
  output logic              frame_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int RW        = $clog2(MAX_HEIGHT);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int SW        = $clog2(MAX_WINDOW + 1);
  localparam int AHEAD_MAX = MAX_WINDOW - 1 - MAX_WINDOW / 2;
  localparam int GAW       = $clog2(AHEAD_MAX * MAX_WIDTH + AHEAD_MAX + 1);
  localparam int PW        = $clog2(MAX_WIDTH * (MAX_HEIGHT + AHEAD_MAX + 1) + 1);

  logic [4:0]        cfg_wsize;
  logic [10:0]       cfg_fwidth, cfg_fheight;
  logic [SW-1:0]     s_eff, rad, ahead;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic [PW-1:0]     lag, pos, rd_pos;
  logic [CW-1:0]     col, ec;
  logic [RW-1:0]     er;
  logic              in_fire, emit, fe, pix_bit;
  logic [GRAY_W-1:0] gray_in, gray_rd;
  logic              res_vld;
  res_t              res, out_res;
  logic [1:0]        inflight;
  logic [2:0]        q_count;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_wsize == 5'd0) s_eff = SW'(1);
    else if (32'(cfg_wsize) > MAX_WINDOW) s_eff = SW'(MAX_WINDOW);
    else s_eff = SW'(cfg_wsize);
    if (cfg_fwidth == 11'd0) w_eff = WW'(1);
    else if (32'(cfg_fwidth) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_fwidth);
    if (cfg_fheight == 11'd0) h_eff = HW'(1);
    else if (32'(cfg_fheight) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg_fheight);
  end

  assign rad   = s_eff >> 1;
  assign ahead = s_eff - SW'(1) - rad;
  assign lag   = PW'(ahead) * PW'(w_eff) + PW'(ahead);

  // Room in the queue is reserved for every item still in the pipeline.
  assign in_ready = ({1'b0, q_count} + {2'b0, inflight}) < 4'd4;
  assign in_fire  = in_valid && in_ready;
  assign emit     = pos >= lag;
  assign fe       = (WW'(ec) == w_eff - WW'(1)) && (HW'(er) == h_eff - HW'(1));
  assign pix_bit  = !drain && (pixel_gray != '0);
  assign gray_in  = drain ? '0 : pixel_gray;
  assign rd_pos   = pos - lag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_wsize   <= RST_WINDOW_SIZE;
      cfg_fwidth  <= RST_FRAME_WIDTH;
      cfg_fheight <= RST_FRAME_HEIGHT;
      pos <= '0;
      col <= '0;
      er  <= '0;
      ec  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_SIZE: begin
          cfg_wsize <= cfg_data[4:0];
          pos <= '0; col <= '0; er <= '0; ec <= '0;
        end
        REG_FRAME_WIDTH: begin
          cfg_fwidth <= cfg_data;
          pos <= '0; col <= '0; er <= '0; ec <= '0;
        end
        REG_FRAME_HEIGHT: begin
          cfg_fheight <= cfg_data;
          pos <= '0; col <= '0; er <= '0; ec <= '0;
        end
        default: ;
      endcase
    end else if (in_fire) begin
      if (emit && fe) begin
        pos <= '0;
        col <= '0;
        er  <= '0;
        ec  <= '0;
      end else begin
        pos <= pos + PW'(1);
        if (WW'(col) + WW'(1) >= w_eff) col <= '0;
        else col <= col + CW'(1);
        if (emit) begin
          if (WW'(ec) + WW'(1) >= w_eff) begin
            ec <= '0;
            er <= er + RW'(1);
          end else begin
            ec <= ec + CW'(1);
          end
        end
      end
    end
  end

  ebu_ram #(.WIDTH(GRAY_W), .DEPTH(2 ** GAW)) u_delay (
    .clk   (clk),
    .we    (in_fire),
    .waddr (pos[GAW-1:0]),
    .wdata (gray_in),
    .raddr (rd_pos[GAW-1:0]),
    .rdata (gray_rd)
  );

  ebu_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .step     (in_fire),
    .col      (col),
    .pix_bit  (pix_bit),
    .gray_in  (gray_in),
    .emit     (emit),
    .er       (er),
    .ec       (ec),
    .fe       (fe),
    .lag0     (lag == '0),
    .gray_rd  (gray_rd),
    .s_eff    (s_eff),
    .ahead    (ahead),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .res_vld  (res_vld),
    .res      (res),
    .inflight (inflight)
  );

  ebu_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_vld),
    .push_data (res),
    .pop_vld   (out_valid),
    .pop_rdy   (out_ready),
    .pop_data  (out_res),
    .count     (q_count)
  );

  assign eroded_gray   = out_res.eroded_gray;
  assign boundary_gray = out_res.boundary_gray;
  assign frame_end     = out_res.frame_end;

endmodule

// File: design/ebu_checker.sv
module ebu_checker import ebu_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [GRAY_W-1:0] eroded_gray,
  input logic [GRAY_W-1:0] boundary_gray,
  input logic              frame_end
);

  // A pixel is never both kept by the erosion and shown on the boundary.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (eroded_gray == '0 || boundary_gray == '0))
    else $error("eroded and boundary both nonzero");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(eroded_gray)
      && $stable(boundary_gray) && $stable(frame_end))
    else $error("stalled result item changed");

endmodule

bind binary_erosion_boundary_unit ebu_checker u_ebu_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .eroded_gray   (eroded_gray),
  .boundary_gray (boundary_gray),
  .frame_end     (frame_end)
);
